/* rtl/section_write_combining_buffer_macros.svh */
// Assertion macros for the section write-combining buffer checker
`ifndef SECTION_WRITE_COMBINING_BUFFER_MACROS_SVH
`define SECTION_WRITE_COMBINING_BUFFER_MACROS_SVH
// Assert that an implication holds at every clock edge outside reset
`define SWCB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assert that a signal holds while a shown word is stalled
`define SWCB_HOLD(label, clk, rstn, vld, rdy, sig, msg) \
    `SWCB_ASSERT(label, clk, rstn, (vld && !rdy) |=> $stable(sig), msg)
`endif

/* rtl/swcb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swcb_pkg
// Shared types and constants of the section write-combining buffer.
// ----------------------------------------------------------------------------
package swcb_pkg;
    localparam int NUM_SECTIONS_DEF = 20;
    localparam int NUM_SLOTS_DEF    = 4;
    localparam int SLOT_BYTES_DEF   = 128;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_SIZE   = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;
    localparam logic [1:0] CMD_RSVD   = 2'd3;   // unused, ignored

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture the input request
        logic hit_wr;    // write byte into hit slot / claim slot
        logic rc_start;  // start address recompute walk
        logic rc_step;   // advance recompute walk
        logic em_start;  // start emitting a slot
        logic em_step;   // a word was sent
        logic em_done;   // finish emitting: advance address, free slot
        logic sel_next;  // advance flush scan slot
    } swcb_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic cmd_valid_sec; // section in range
        logic hit;
        logic hit_full;      // hit slot becomes full after this byte
        logic victim_busy;   // miss victim holds bytes that must leave
        logic rc_last;
        logic em_last;       // current word is the last of the slot
        logic em_empty;      // selected slot has nothing to emit
        logic scan_valid;    // flush scan slot is owned
        logic scan_last;     // flush scan slot is the last slot
        logic any_later;     // an owned, non-empty slot remains after scan slot
    } swcb_sts_t;
endpackage
`default_nettype wire

/* rtl/section_write_combining_buffer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// section_write_combining_buffer
// Collects appended bytes per section in slot buffers, emits words of up to 8 bytes.
// ----------------------------------------------------------------------------
// An append is accepted in the idle state and then decoded: a hit or a free
// slot takes the byte directly; when the slot fills or a victim is evicted,
// each written word passes a memory read state, then the output handshake. A
// set size walks all sections, one section per cycle. A flush scans the slots
// one by one and emits each word of an owned, non-empty slot the same way.
// Output stalls hold the emission; the slot memory read is registered.
module section_write_combining_buffer #(
    parameter int NUM_SECTIONS = swcb_pkg::NUM_SECTIONS_DEF,
    parameter int NUM_SLOTS    = swcb_pkg::NUM_SLOTS_DEF,
    parameter int SLOT_BYTES   = swcb_pkg::SLOT_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [4:0]  s_section,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic [31:0] s_section_length,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_write_address,
    output logic [63:0]      m_write_data,
    output logic [3:0]       m_byte_count,
    output logic             m_last
);
    logic [31:0] base_offset_reg;
    swcb_pkg::swcb_cmd_t cmd;
    swcb_pkg::swcb_sts_t sts;

    // Hold the base offset register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_offset_reg <= '0;
        end else if (cfg_valid) begin
            base_offset_reg <= cfg_data;
        end
    end

    swcb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_last  (m_last),
        .cmd     (cmd),
        .sts     (sts)
    );

    swcb_dp #(
        .NUM_SECTIONS (NUM_SECTIONS),
        .NUM_SLOTS    (NUM_SLOTS),
        .SLOT_BYTES   (SLOT_BYTES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .base_offset      (base_offset_reg),
        .s_cmd            (s_cmd),
        .s_section        (s_section),
        .s_data_byte      (s_data_byte),
        .s_section_length (s_section_length),
        .m_write_address  (m_write_address),
        .m_write_data     (m_write_data),
        .m_byte_count     (m_byte_count),
        .cmd              (cmd),
        .sts              (sts)
    );
endmodule
`default_nettype wire

/* rtl/swcb_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swcb_ctrl
// Control state machine: sequences append, recompute, and flush requests.
// ----------------------------------------------------------------------------
module swcb_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_cmd,
    input  wire logic                m_ready,
    output logic                     m_valid,
    output logic                     m_last,
    output swcb_pkg::swcb_cmd_t      cmd,
    input  wire swcb_pkg::swcb_sts_t sts
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DEC   = 3'd1;
    localparam logic [2:0] ST_RC    = 3'd2;
    localparam logic [2:0] ST_EMRD  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_SCAN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic       fin_reg, fin_next;   // this emit ends the request

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= '0;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            fin_reg   <= fin_next;
        end
    end

    // Sequence one request at a time
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        m_last     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    op_next    = s_cmd;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                state_next = ST_IDLE;
                if (op_reg == swcb_pkg::CMD_APPEND && sts.cmd_valid_sec) begin
                    if (sts.hit) begin
                        cmd.hit_wr = 1'b1;
                        if (sts.hit_full) begin
                            cmd.em_start = 1'b1;
                            fin_next     = 1'b1;
                            state_next   = ST_EMRD;
                        end
                    end else if (sts.victim_busy) begin
                        // evict first; the byte is written after emission
                        cmd.em_start = 1'b1;
                        fin_next     = 1'b1;
                        state_next   = ST_EMRD;
                    end else begin
                        cmd.hit_wr = 1'b1;
                    end
                end else if (op_reg == swcb_pkg::CMD_SIZE && sts.cmd_valid_sec) begin
                    cmd.rc_start = 1'b1;
                    state_next   = ST_RC;
                end else if (op_reg == swcb_pkg::CMD_FLUSH) begin
                    state_next = ST_SCAN;
                end
            end
            ST_RC: begin
                cmd.rc_step = 1'b1;
                if (sts.rc_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (sts.scan_valid && !sts.em_empty) begin
                    cmd.em_start = 1'b1;
                    fin_next     = !sts.any_later;
                    state_next   = ST_EMRD;
                end else begin
                    // owned but empty slots are just freed
                    if (sts.scan_valid) begin
                        cmd.em_done = 1'b1;
                    end
                    cmd.sel_next = 1'b1;
                    if (sts.scan_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMRD: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                m_last  = fin_reg && sts.em_last;
                if (m_ready) begin
                    cmd.em_step = 1'b1;
                    if (sts.em_last) begin
                        cmd.em_done = 1'b1;
                        if (op_reg == swcb_pkg::CMD_FLUSH) begin
                            cmd.sel_next = 1'b1;
                            state_next   = sts.scan_last ? ST_IDLE : ST_SCAN;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        state_next = ST_EMRD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/swcb_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swcb_dp
// Datapath: section tables, slot tags, slot byte memory and word assembly.
// ----------------------------------------------------------------------------
module swcb_dp #(
    parameter int NUM_SECTIONS = swcb_pkg::NUM_SECTIONS_DEF,
    parameter int NUM_SLOTS    = swcb_pkg::NUM_SLOTS_DEF,
    parameter int SLOT_BYTES   = swcb_pkg::SLOT_BYTES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [31:0]         base_offset,
    input  wire logic [1:0]          s_cmd,
    input  wire logic [4:0]          s_section,
    input  wire logic [7:0]          s_data_byte,
    input  wire logic [31:0]         s_section_length,
    output logic [31:0]              m_write_address,
    output logic [63:0]              m_write_data,
    output logic [3:0]               m_byte_count,
    input  wire swcb_pkg::swcb_cmd_t cmd,
    output swcb_pkg::swcb_sts_t      sts
);
    localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SECW = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam int WPS = (SLOT_BYTES + 7) / 8;              // words per slot
    localparam int WW  = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int FW  = $clog2(SLOT_BYTES + 1);
    localparam int DEPTH = NUM_SLOTS * WPS;
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Next slot index, wrapping at the last slot
    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] v);
        return (32'(v) == NUM_SLOTS - 1) ? '0 : v + 1'b1;
    endfunction

    // Captured request
    logic [1:0]  op_reg;
    logic [4:0]  sec_reg;
    logic [7:0]  byte_reg;
    logic [31:0] len_reg;

    // Section tables
    logic [31:0] sec_addr_reg [NUM_SECTIONS];
    logic [31:0] sec_size_reg [NUM_SECTIONS];

    // Slot tags
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [SECW-1:0]      owner_reg [NUM_SLOTS];
    logic [FW-1:0]        fill_reg  [NUM_SLOTS];
    logic [SW-1:0]        rot_reg;

    // Slot byte memory, one 8-byte word per row with per-byte writes
    logic [63:0] mem [DEPTH];
    logic [63:0] rd_reg;

    // Emission state
    logic [SW-1:0]  sel_reg;      // slot being emitted / scanned
    logic [WW-1:0]  word_reg;
    logic           pend_reg;     // append after eviction pending
    logic [SW-1:0]  pick_reg;     // slot chosen in decode

    // Recompute walk
    logic [SECW-1:0] rc_idx_reg;
    logic [31:0]     rc_acc_reg;

    logic [SW-1:0]  hit_idx, free_idx, pick;
    logic           hit, free_found;
    logic [SECW-1:0] sec_idx;

    assign sec_idx = sec_reg[SECW-1:0];

    // Tag compare and round-robin free search
    always_comb begin
        logic [SW-1:0] c;
        logic [SW:0]   sum;
        hit = 1'b0;
        hit_idx = '0;
        free_found = 1'b0;
        free_idx = rot_reg;
        c = '0;
        sum = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!hit && valid_reg[i] && owner_reg[i] == sec_idx) begin
                hit = 1'b1;
                hit_idx = SW'(i);
            end
        end
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            sum = {1'b0, rot_reg} + (SW+1)'(i);
            if (sum >= (SW+1)'(NUM_SLOTS)) sum = sum - (SW+1)'(NUM_SLOTS);
            c = sum[SW-1:0];
            if (!valid_reg[c]) begin
                free_found = 1'b1;
                free_idx = c;
            end
        end
    end
    assign pick = hit ? hit_idx : free_idx;

    // Status toward the controller
    logic [FW-1:0] sel_fill;
    logic [FW:0]   rem;
    assign sel_fill = fill_reg[sel_reg];
    assign rem = {1'b0, sel_fill} - {1'b0, FW'({word_reg, 3'b000})};
    always_comb begin
        logic any;
        any = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i > 32'(sel_reg) && valid_reg[i] && fill_reg[i] != '0) any = 1'b1;
        end
        sts.any_later     = any;
        sts.cmd_valid_sec = 32'(sec_reg) < NUM_SECTIONS;
        sts.hit           = hit;
        sts.hit_full      = 32'(fill_reg[hit_idx]) + 1 >= SLOT_BYTES;
        sts.victim_busy   = !free_found && fill_reg[rot_reg] != '0;
        sts.rc_last       = 32'(rc_idx_reg) == NUM_SECTIONS - 1;
        sts.em_last       = rem <= (FW+1)'(8);
        sts.em_empty      = sel_fill == '0;
        sts.scan_valid    = valid_reg[sel_reg];
        sts.scan_last     = 32'(sel_reg) == NUM_SLOTS - 1;
    end

    // Output word
    logic [3:0] cnt;
    assign cnt = (rem >= (FW+1)'(8)) ? 4'd8 : 4'(rem);
    assign m_byte_count = cnt;
    assign m_write_address = sec_addr_reg[owner_reg[sel_reg]] + 32'({word_reg, 3'b000});
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            m_write_data[8*k +: 8] = (k < 32'(cnt)) ? rd_reg[8*k +: 8] : 8'h00;
        end
    end

    // Byte write target
    logic          wr_en;
    logic [SW-1:0] wr_slot;
    logic [FW-1:0] wr_pos;
    always_comb begin
        wr_en   = 1'b0;
        wr_slot = pick;
        wr_pos  = '0;
        if (cmd.hit_wr) begin
            wr_en  = 1'b1;
            wr_pos = hit ? fill_reg[hit_idx] : '0;
        end else if (cmd.em_done && pend_reg) begin
            wr_en   = 1'b1;
            wr_slot = pick_reg;
        end
    end

    // Memory: byte write, registered word read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[AW'(32'(wr_slot) * WPS + 32'(wr_pos >> 3))][8*wr_pos[2:0] +: 8] <= byte_reg;
        end
        rd_reg <= mem[AW'(32'(sel_reg) * WPS + 32'(word_reg))];
    end

    // Capture request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_cmd;
            sec_reg  <= s_section;
            byte_reg <= s_data_byte;
            len_reg  <= s_section_length;
        end
    end

    // Control state of tables and slots
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rot_reg    <= '0;
            sel_reg    <= '0;
            word_reg   <= '0;
            pend_reg   <= 1'b0;
            pick_reg   <= '0;
            rc_idx_reg <= '0;
            rc_acc_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                owner_reg[i] <= '0;
                fill_reg[i]  <= '0;
            end
            for (int i = 0; i < NUM_SECTIONS; i++) begin
                sec_addr_reg[i] <= '0;
                sec_size_reg[i] <= '0;
            end
        end else begin
            if (cmd.load) begin
                sel_reg  <= '0;
                word_reg <= '0;
            end
            // append into hit or fresh slot
            if (cmd.hit_wr) begin
                if (hit) begin
                    fill_reg[hit_idx] <= fill_reg[hit_idx] + 1'b1;
                end else begin
                    valid_reg[pick] <= 1'b1;
                    owner_reg[pick] <= sec_idx;
                    fill_reg[pick]  <= FW'(1);
                    rot_reg <= slot_inc(rot_reg);
                end
            end
            if (cmd.em_start) begin
                word_reg <= '0;
                if (op_reg == swcb_pkg::CMD_APPEND) begin
                    sel_reg  <= pick;
                    pick_reg <= pick;
                    pend_reg <= !hit;
                end else begin
                    pend_reg <= 1'b0;
                end
            end
            if (cmd.em_step) begin
                word_reg <= word_reg + 1'b1;
            end
            if (cmd.em_done) begin
                sec_addr_reg[owner_reg[sel_reg]] <=
                    sec_addr_reg[owner_reg[sel_reg]] + 32'(sel_fill);
                fill_reg[sel_reg]  <= '0;
                valid_reg[sel_reg] <= 1'b0;
                word_reg <= '0;
                if (pend_reg) begin
                    // evicted slot is reclaimed for the new section
                    valid_reg[pick_reg] <= 1'b1;
                    owner_reg[pick_reg] <= sec_idx;
                    fill_reg[pick_reg]  <= FW'(1);
                    rot_reg  <= slot_inc(rot_reg);
                    pend_reg <= 1'b0;
                end
            end
            if (cmd.sel_next) begin
                sel_reg  <= slot_inc(sel_reg);
                word_reg <= '0;
            end
            // recompute walk: one section a cycle
            if (cmd.rc_start) begin
                sec_size_reg[sec_idx] <= len_reg;
                rc_idx_reg <= '0;
                rc_acc_reg <= base_offset;
            end
            if (cmd.rc_step) begin
                sec_addr_reg[rc_idx_reg] <= rc_acc_reg;
                rc_acc_reg <= rc_acc_reg + sec_size_reg[rc_idx_reg];
                rc_idx_reg <= rc_idx_reg + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/swcb_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swcb_checker
// Port-level checks of the section write-combining buffer.
// ----------------------------------------------------------------------------
`include "section_write_combining_buffer_macros.svh"
module swcb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [3:0]  m_byte_count,
    input wire logic [31:0] m_write_address,
    input wire logic        m_last
);
    // Count is always one to eight bytes
    `SWCB_ASSERT(a_count, aclk, aresetn, m_valid |-> (m_byte_count != 4'd0 && m_byte_count <= 4'd8), "byte count out of range")
    // No new request accepted while a word is shown
    `SWCB_ASSERT(a_excl, aclk, aresetn, m_valid |-> !s_ready, "input ready during output")
    // A word stalled keeps its address
    `SWCB_HOLD(a_hold, aclk, aresetn, m_valid, m_ready, m_write_address, "stalled address changed")
    // A word stalled keeps its last flag
    `SWCB_HOLD(a_last_stable, aclk, aresetn, m_valid, m_ready, m_last, "stalled last changed")
    // A word stalled stays shown
    `SWCB_HOLD(a_valid_hold, aclk, aresetn, m_valid, m_ready, m_valid, "stalled valid dropped")
endmodule

bind section_write_combining_buffer swcb_checker u_swcb_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_byte_count    (m_byte_count),
    .m_write_address (m_write_address),
    .m_last          (m_last)
);
`default_nettype wire
